/* hdl/fpa_pkg.sv */
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Shared constants, command codes and transaction types for the fixed-point
// ALU front end, operation queue and execution back end.
// ----------------------------------------------------------------------------
package fpa_pkg;

  // Number of fractional bits in the raw fixed-point format.
  localparam int FRAC_BITS = 8;
  localparam int DATA_W    = 32;

  // Dividend width of the divider: magnitude of operand_a shifted left.
  localparam int DIV_W = DATA_W + FRAC_BITS;

  // Depth of the queue between the front end and the back end.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Rounding bias that turns an arithmetic shift into truncation toward zero.
  localparam logic [63:0] MUL_BIAS = (64'd1 << FRAC_BITS) - 64'd1;

  // Command codes.
  typedef enum logic [3:0] {
    CMD_ADD      = 4'd0,
    CMD_SUB      = 4'd1,
    CMD_MUL      = 4'd2,
    CMD_DIV      = 4'd3,
    CMD_MIN      = 4'd4,
    CMD_MAX      = 4'd5,
    CMD_LT       = 4'd6,
    CMD_GT       = 4'd7,
    CMD_LE       = 4'd8,
    CMD_GE       = 4'd9,
    CMD_EQ       = 4'd10,
    CMD_NE       = 4'd11,
    CMD_INC      = 4'd12,
    CMD_DEC      = 4'd13,
    CMD_FROM_INT = 4'd14
  } cmd_e;

  // Execution class assigned by the front end.
  typedef enum logic [1:0] {
    KIND_SIMPLE,
    KIND_MUL,
    KIND_DIV
  } kind_e;

  // Request transaction payload.
  typedef struct packed {
    logic [3:0]               cmd;
    logic signed [DATA_W-1:0] operand_a;
    logic signed [DATA_W-1:0] operand_b;
  } req_t;

  // Response transaction payload.
  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic                     compare_flag;
    logic                     divide_by_zero;
  } rsp_t;

  // Classified operation held in the queue.
  typedef struct packed {
    kind_e              kind;
    logic [DATA_W-1:0]  res;
    logic               flag;
    logic               dz;
    logic               neg;
    logic [DATA_W-1:0]  opa;
    logic [DATA_W-1:0]  opb;
  } entry_t;

  // One stage of the execution pipeline.
  typedef struct packed {
    kind_e              kind;
    logic [DATA_W-1:0]  res;
    logic               flag;
    logic               dz;
    logic               neg;
    logic [DATA_W-1:0]  rem;
    logic [DIV_W-1:0]   quo;
    logic [DATA_W-1:0]  dvs;
  } stage_t;

endpackage

/* hdl/fixed_point_alu.sv */
// ----------------------------------------------------------------------------
// Fixed-point ALU
// Signed fixed-point ALU: front end, operation queue and execution back end.
// ----------------------------------------------------------------------------
// Every operation rides the one-bit-per-stage divider pipeline.
// Throughput: one transaction per cycle unless the response side stalls;
// the queue decouples the two ends.
// Reset: synchronous, active high; clears the queue and all valid bits.
module fixed_point_alu (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  fpa_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output fpa_pkg::rsp_t rsp
);

  logic            q_ready;
  logic            q_push;
  fpa_pkg::entry_t q_data;
  logic            q_pop;
  fpa_pkg::entry_t q_head;
  logic            q_has_item;

  // Front end: accept and classify.
  fpa_front u_front (
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_data    (q_data)
  );

  // Queue between the two ends.
  fpa_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .ready     (q_ready),
    .pop       (q_pop),
    .head      (q_head),
    .has_item  (q_has_item)
  );

  // Back end: execute and deliver.
  fpa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (q_head),
    .has_item  (q_has_item),
    .pop       (q_pop),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

`ifndef ASSERT_OFF
  // A divide by zero response carries a zero result and no flag.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.divide_by_zero |-> rsp.result_value == '0 && !rsp.compare_flag)
    else $error("divide by zero response has nonzero payload");

  // A comparison response carries a zero result value.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.compare_flag |-> rsp.result_value == '0 && !rsp.divide_by_zero)
    else $error("comparison response has nonzero result");

  // After reset the queue is empty and no response is pending.
  assert property (@(posedge clk)
    rst |=> !rsp_valid && req_ready)
    else $error("state not cleared by reset");
`endif

endmodule

/* hdl/fpa_front.sv */
// ----------------------------------------------------------------------------
// Fixed-point ALU front end
// Accepts request transactions, finishes the simple operations and
// prepares multiply and divide operands for the back end.
// ----------------------------------------------------------------------------
module fpa_front (
  input  logic           req_valid,
  output logic           req_ready,
  input  fpa_pkg::req_t  req,
  input  logic           q_ready,
  output logic           q_push,
  output fpa_pkg::entry_t q_data
);

  logic signed [fpa_pkg::DATA_W-1:0] a;
  logic signed [fpa_pkg::DATA_W-1:0] b;
  logic [fpa_pkg::DATA_W-1:0] sum;
  logic [fpa_pkg::DATA_W-1:0] dif;
  logic [fpa_pkg::DATA_W-1:0] abs_a;
  logic [fpa_pkg::DATA_W-1:0] abs_b;
  logic lt;
  logic eq;

  // Handshake: a transaction goes straight into the queue.
  assign req_ready = q_ready;
  assign q_push    = req_valid && q_ready;

  // Shared arithmetic for the simple operations and divide operands.
  assign a     = req.operand_a;
  assign b     = req.operand_b;
  assign sum   = a + b;
  assign dif   = a - b;
  assign lt    = a < b;
  assign eq    = a == b;
  assign abs_a = a[fpa_pkg::DATA_W-1] ? (~a + 1'b1) : a;
  assign abs_b = b[fpa_pkg::DATA_W-1] ? (~b + 1'b1) : b;

  // Classify the command and fill in the queue entry.
  always_comb begin
    q_data      = '0;
    q_data.kind = fpa_pkg::KIND_SIMPLE;
    unique case (req.cmd)
      fpa_pkg::CMD_ADD: q_data.res = sum;
      fpa_pkg::CMD_SUB: q_data.res = dif;
      fpa_pkg::CMD_MUL: begin
        q_data.kind = fpa_pkg::KIND_MUL;
        q_data.opa  = a;
        q_data.opb  = b;
      end
      fpa_pkg::CMD_DIV: begin
        q_data.kind = fpa_pkg::KIND_DIV;
        q_data.opa  = abs_a;
        q_data.opb  = abs_b;
        q_data.neg  = a[fpa_pkg::DATA_W-1] ^ b[fpa_pkg::DATA_W-1];
        q_data.dz   = (b == '0);
      end
      fpa_pkg::CMD_MIN:      q_data.res  = lt ? a : b;
      fpa_pkg::CMD_MAX:      q_data.res  = (!lt && !eq) ? a : b;
      fpa_pkg::CMD_LT:       q_data.flag = lt;
      fpa_pkg::CMD_GT:       q_data.flag = !lt && !eq;
      fpa_pkg::CMD_LE:       q_data.flag = lt || eq;
      fpa_pkg::CMD_GE:       q_data.flag = !lt;
      fpa_pkg::CMD_EQ:       q_data.flag = eq;
      fpa_pkg::CMD_NE:       q_data.flag = !eq;
      fpa_pkg::CMD_INC:      q_data.res  = a + 1'b1;
      fpa_pkg::CMD_DEC:      q_data.res  = a - 1'b1;
      fpa_pkg::CMD_FROM_INT: q_data.res  = a << fpa_pkg::FRAC_BITS;
      default:               q_data.res  = '0;
    endcase
  end

endmodule

/* hdl/fpa_queue.sv */
// ----------------------------------------------------------------------------
// Fixed-point ALU operation queue
// Small first-in first-out buffer that decouples the front end from the
// execution back end.
// ----------------------------------------------------------------------------
module fpa_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  fpa_pkg::entry_t push_data,
  output logic            ready,
  input  logic            pop,
  output fpa_pkg::entry_t head,
  output logic            has_item
);

  fpa_pkg::entry_t mem [fpa_pkg::QDEPTH];
  logic [fpa_pkg::QPTR_W-1:0] wptr;
  logic [fpa_pkg::QPTR_W-1:0] rptr;
  logic [fpa_pkg::QPTR_W:0]   count;

  assign ready    = (count != fpa_pkg::QDEPTH);
  assign has_item = (count != '0);
  assign head     = mem[rptr];

  // Pointer and occupancy tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

endmodule

/* hdl/fpa_back.sv */
// ----------------------------------------------------------------------------
// Fixed-point ALU back end
// Execution pipeline: a registered multiplier with truncating rescale and a
// one-bit-per-stage restoring divider, with all operations kept in order.
// ----------------------------------------------------------------------------
module fpa_back (
  input  logic            clk,
  input  logic            rst,
  input  fpa_pkg::entry_t head,
  input  logic            has_item,
  output logic            pop,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output fpa_pkg::rsp_t   rsp
);

  fpa_pkg::stage_t st        [fpa_pkg::DIV_W+1];
  fpa_pkg::stage_t step_next [fpa_pkg::DIV_W];
  logic [fpa_pkg::DIV_W:0] vld;
  logic                    adv;
  logic signed [63:0]      mul_prod;
  logic [63:0]             mul_adj;
  logic [fpa_pkg::DATA_W-1:0] mul_res;
  fpa_pkg::rsp_t           rsp_next;

  // One restoring division step: one quotient bit per stage.
  function automatic fpa_pkg::stage_t div_step(input fpa_pkg::stage_t s);
    logic [fpa_pkg::DATA_W:0]   r;
    logic [fpa_pkg::DATA_W+1:0] d;
    fpa_pkg::stage_t            o;
    o = s;
    r = {s.rem, s.quo[fpa_pkg::DIV_W-1]};
    d = {1'b0, r} - {2'b00, s.dvs};
    if (!d[fpa_pkg::DATA_W+1]) begin
      o.rem = d[fpa_pkg::DATA_W-1:0];
      o.quo = {s.quo[fpa_pkg::DIV_W-2:0], 1'b1};
    end else begin
      o.rem = r[fpa_pkg::DATA_W-1:0];
      o.quo = {s.quo[fpa_pkg::DIV_W-2:0], 1'b0};
    end
    return o;
  endfunction

  // The whole pipeline moves when the output register is free or drains.
  assign adv = !rsp_valid || rsp_ready;
  assign pop = adv && has_item;

  // Multiply rescale: bias negative products so the shift truncates to zero.
  assign mul_adj = mul_prod + (mul_prod[63] ? fpa_pkg::MUL_BIAS : 64'd0);
  assign mul_res = mul_adj[fpa_pkg::FRAC_BITS +: fpa_pkg::DATA_W];

  // Next value of every stage after the load stage.
  always_comb begin
    for (int k = 0; k < fpa_pkg::DIV_W; k++) begin
      step_next[k] = div_step(st[k]);
    end
    if (st[0].kind == fpa_pkg::KIND_MUL) begin
      step_next[0].res = mul_res;
    end
  end

  // Final sign correction and result selection.
  always_comb begin
    rsp_next = '0;
    unique case (st[fpa_pkg::DIV_W].kind)
      fpa_pkg::KIND_DIV: begin
        rsp_next.divide_by_zero = st[fpa_pkg::DIV_W].dz;
        if (!st[fpa_pkg::DIV_W].dz) begin
          rsp_next.result_value = st[fpa_pkg::DIV_W].neg
              ? (~st[fpa_pkg::DIV_W].quo[fpa_pkg::DATA_W-1:0] + 1'b1)
              : st[fpa_pkg::DIV_W].quo[fpa_pkg::DATA_W-1:0];
        end
      end
      fpa_pkg::KIND_MUL: rsp_next.result_value = st[fpa_pkg::DIV_W].res;
      fpa_pkg::KIND_SIMPLE: begin
        rsp_next.result_value = st[fpa_pkg::DIV_W].res;
        rsp_next.compare_flag = st[fpa_pkg::DIV_W].flag;
      end
      default: rsp_next = '0;
    endcase
  end

  // Stage valid bits and the output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      rsp_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[fpa_pkg::DIV_W-1:0], has_item};
      rsp_valid <= vld[fpa_pkg::DIV_W];
    end
  end

  // Pipeline payload: load from the queue head, step, then the output.
  always_ff @(posedge clk) begin
    if (adv) begin
      st[0].kind <= head.kind;
      st[0].res  <= head.res;
      st[0].flag <= head.flag;
      st[0].dz   <= head.dz;
      st[0].neg  <= head.neg;
      st[0].rem  <= '0;
      st[0].quo  <= fpa_pkg::DIV_W'(head.opa) << fpa_pkg::FRAC_BITS;
      st[0].dvs  <= head.opb;
      mul_prod   <= $signed(head.opa) * $signed(head.opb);
      for (int k = 0; k < fpa_pkg::DIV_W; k++) begin
        st[k+1] <= step_next[k];
      end
      rsp <= rsp_next;
    end
  end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-point ALU testbench
// Drives command transactions into the ALU with random gaps and back-pressure.
// Every accepted command gets an expected response, hand-typed or from a model
// of the Q24.8 arithmetic. Each response is compared field by field, in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int N_RANDOM   = 1330;
  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_WAIT = 60;
  localparam int HOLD_LEN   = 400;

  // One directed stimulus row, with an optional hand-typed answer.
  typedef struct packed {
    fpa_pkg::req_t req;
    logic          known;
    fpa_pkg::rsp_t want;
  } vec_t;

  logic          clk;
  logic          rst;
  logic          req_valid;
  logic          req_ready;
  fpa_pkg::req_t req;
  logic          rsp_valid;
  logic          rsp_ready;
  fpa_pkg::rsp_t rsp;

  fpa_pkg::rsp_t alu_answers[$];
  vec_t          directed[$];

  int n_sent;
  int n_checked;
  int n_dz_seen;
  int mismatches;
  int idle_cycles;
  bit no_idle;
  bit rsp_hold;
  bit pressure_done;

  fixed_point_alu u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Golden arithmetic: exact at 64 bits, then wrapped to 32.
  function automatic fpa_pkg::rsp_t alu_compute(fpa_pkg::req_t r);
    longint        a;
    longint        b;
    longint        scale;
    longint        full;
    fpa_pkg::rsp_t o;
    a     = longint'($signed(r.operand_a));
    b     = longint'($signed(r.operand_b));
    scale = longint'(1) << fpa_pkg::FRAC_BITS;
    full  = 0;
    o     = '0;
    case (fpa_pkg::cmd_e'(r.cmd))
      fpa_pkg::CMD_ADD:      full = a + b;
      fpa_pkg::CMD_SUB:      full = a - b;
      fpa_pkg::CMD_MUL:      full = (a * b) / scale;
      fpa_pkg::CMD_DIV: begin
        if (b == 0) o.divide_by_zero = 1'b1;
        else full = (a * scale) / b;
      end
      fpa_pkg::CMD_MIN:      full = (a < b) ? a : b;
      fpa_pkg::CMD_MAX:      full = (a > b) ? a : b;
      fpa_pkg::CMD_LT:       o.compare_flag = (a < b);
      fpa_pkg::CMD_GT:       o.compare_flag = (a > b);
      fpa_pkg::CMD_LE:       o.compare_flag = (a <= b);
      fpa_pkg::CMD_GE:       o.compare_flag = (a >= b);
      fpa_pkg::CMD_EQ:       o.compare_flag = (a == b);
      fpa_pkg::CMD_NE:       o.compare_flag = (a != b);
      fpa_pkg::CMD_INC:      full = a + 1;
      fpa_pkg::CMD_DEC:      full = a - 1;
      fpa_pkg::CMD_FROM_INT: full = a * scale;
      default:               full = 0;
    endcase
    o.result_value = full[31:0];
    return o;
  endfunction

  function automatic vec_t mk_row(fpa_pkg::cmd_e c, logic [31:0] a, logic [31:0] b,
                                  logic known, logic [31:0] res, logic flag, logic dz);
    vec_t v;
    v.req.cmd             = c;
    v.req.operand_a       = a;
    v.req.operand_b       = b;
    v.known               = known;
    v.want.result_value   = res;
    v.want.compare_flag   = flag;
    v.want.divide_by_zero = dz;
    return v;
  endfunction

  // Operand mix: full range, small values, whole numbers, powers of two, extremes.
  function automatic logic [31:0] pick_operand();
    logic [31:0] v;
    int          s;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4, 5: begin
        s = int'($urandom_range(0, 4095)) - 2048;
        v = s;
      end
      6: begin
        s = int'($urandom_range(0, 200)) - 100;
        v = s << fpa_pkg::FRAC_BITS;
      end
      7: begin
        v = 32'd1 << $urandom_range(0, 31);
        if ($urandom_range(0, 1)) v = -v;
      end
      8: begin
        case ($urandom_range(0, 4))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'h0000_0000;
          3: v = 32'hFFFF_FFFF;
          default: v = 32'h0000_0001;
        endcase
      end
      default: begin
        v = $urandom_range(0, 15);
        if ($urandom_range(0, 1)) v = 32'h7FFF_FFFF - v;
        else v = 32'h8000_0000 + v;
      end
    endcase
    return v;
  endfunction

  // Offer one transaction after a random gap and log its expected response.
  task automatic send_op(fpa_pkg::req_t r, logic known, fpa_pkg::rsp_t want);
    int gap;
    gap = (no_idle || rsp_hold) ? 0 : $urandom_range(0, 11);
    repeat (gap) begin
      @(negedge clk);
      req_valid <= 1'b0;
    end
    @(negedge clk);
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    alu_answers.push_back(known ? want : alu_compute(r));
    n_sent++;
  endtask

  // Response checker: compare every accepted response with the oldest expectation.
  always @(posedge clk) begin
    fpa_pkg::rsp_t exp_rsp;
    if (!rst && rsp_valid && rsp_ready) begin
      if (alu_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected response: result=%h flag=%b dz=%b",
                   rsp.result_value, rsp.compare_flag, rsp.divide_by_zero);
      end else begin
        exp_rsp = alu_answers.pop_front();
        if (rsp.result_value !== exp_rsp.result_value ||
            rsp.compare_flag !== exp_rsp.compare_flag ||
            rsp.divide_by_zero !== exp_rsp.divide_by_zero) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch #%0d: expected result=%h flag=%b dz=%b, got result=%h flag=%b dz=%b",
                     n_checked, exp_rsp.result_value, exp_rsp.compare_flag,
                     exp_rsp.divide_by_zero, rsp.result_value, rsp.compare_flag,
                     rsp.divide_by_zero);
        end
        if (exp_rsp.divide_by_zero) n_dz_seen++;
      end
      n_checked++;
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d responses outstanding",
                 IDLE_LIMIT, alu_answers.size());
        $display("tb: errors");
        $finish;
      end
    end
  end

  // Response side: random stalls, plus one long hold-off to fill the block.
  initial begin : rsp_side
    int stall;
    rsp_ready     = 1'b0;
    rsp_hold      = 1'b0;
    pressure_done = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (!pressure_done && n_checked >= 200) begin
        pressure_done = 1'b1;
        rsp_hold      = 1'b1;
        @(negedge clk);
        rsp_ready <= 1'b0;
        repeat (HOLD_LEN - 1) @(negedge clk);
        rsp_hold = 1'b0;
      end
      stall = (no_idle || rsp_hold) ? 0 : $urandom_range(0, 11);
      repeat (stall) begin
        @(negedge clk);
        rsp_ready <= 1'b0;
      end
      @(negedge clk);
      rsp_ready <= 1'b1;
      @(posedge clk);
      while (!rsp_valid) @(posedge clk);
    end
  end

  // Main sequence: reset, directed table, random traffic, drain, verdict.
  initial begin : stimulus
    fpa_pkg::req_t r;
    fpa_pkg::rsp_t none;
    vec_t          v;
    rst         = 1'b1;
    req_valid   = 1'b0;
    req         = '0;
    n_sent      = 0;
    n_checked   = 0;
    n_dz_seen   = 0;
    mismatches  = 0;
    idle_cycles = 0;
    no_idle     = 1'b0;
    none        = '0;

    // Directed rows: extremes, wrap-around, equal operands, divide by zero.
    directed.push_back(mk_row(fpa_pkg::CMD_ADD, 32'd1, 32'd2, 1, 32'd3, 0, 0));
    directed.push_back(mk_row(fpa_pkg::CMD_ADD, 32'h7FFF_FFFF, 32'd1,
                              1, 32'h8000_0000, 0, 0));
    directed.push_back(mk_row(fpa_pkg::CMD_SUB, 32'h8000_0000, 32'd1,
                              1, 32'h7FFF_FFFF, 0, 0));
    directed.push_back(mk_row(fpa_pkg::CMD_SUB, 32'd0, 32'h8000_0000,
                              1, 32'h8000_0000, 0, 0));
    directed.push_back(mk_row(fpa_pkg::CMD_MUL, 32'h100, 32'h300, 1, 32'h300, 0, 0));
    directed.push_back(mk_row(fpa_pkg::CMD_MUL, 32'hFFFF_FFFF, 32'd1, 1, 32'd0, 0, 0));
    directed.push_back(mk_row(fpa_pkg::CMD_MUL, 32'h8000_0000, 32'h8000_0000,
                              0, '0, 0, 0));
    directed.push_back(mk_row(fpa_pkg::CMD_MUL, 32'h7FFF_FFFF, 32'h8000_0000,
                              0, '0, 0, 0));
    directed.push_back(mk_row(fpa_pkg::CMD_DIV, 32'h100, 32'd0, 1, 32'd0, 0, 1));
    directed.push_back(mk_row(fpa_pkg::CMD_DIV, 32'h8000_0000, 32'd0, 1, 32'd0, 0, 1));
    directed.push_back(mk_row(fpa_pkg::CMD_DIV, 32'h8000_0000, 32'hFFFF_FFFF,
                              0, '0, 0, 0));
    directed.push_back(mk_row(fpa_pkg::CMD_DIV, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                              0, '0, 0, 0));
    directed.push_back(mk_row(fpa_pkg::CMD_DIV, 32'h300, 32'h200, 1, 32'h180, 0, 0));
    directed.push_back(mk_row(fpa_pkg::CMD_MIN, 32'd5, 32'd5, 1, 32'd5, 0, 0));
    directed.push_back(mk_row(fpa_pkg::CMD_MAX, 32'hFFFF_FFF9, 32'hFFFF_FFF9,
                              1, 32'hFFFF_FFF9, 0, 0));
    directed.push_back(mk_row(fpa_pkg::CMD_MIN, 32'h8000_0000, 32'h7FFF_FFFF,
                              1, 32'h8000_0000, 0, 0));
    directed.push_back(mk_row(fpa_pkg::CMD_MAX, 32'h8000_0000, 32'h7FFF_FFFF,
                              1, 32'h7FFF_FFFF, 0, 0));
    directed.push_back(mk_row(fpa_pkg::CMD_LT, 32'h8000_0000, 32'h7FFF_FFFF,
                              1, 32'd0, 1, 0));
    directed.push_back(mk_row(fpa_pkg::CMD_GT, 32'h7FFF_FFFF, 32'h8000_0000,
                              1, 32'd0, 1, 0));
    directed.push_back(mk_row(fpa_pkg::CMD_LE, 32'd3, 32'd3, 1, 32'd0, 1, 0));
    directed.push_back(mk_row(fpa_pkg::CMD_GE, 32'hFFFF_FFFF, 32'd0, 1, 32'd0, 0, 0));
    directed.push_back(mk_row(fpa_pkg::CMD_EQ, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                              1, 32'd0, 1, 0));
    directed.push_back(mk_row(fpa_pkg::CMD_NE, 32'd0, 32'd0, 1, 32'd0, 0, 0));
    directed.push_back(mk_row(fpa_pkg::CMD_INC, 32'h7FFF_FFFF, 32'h5A5A_A5A5,
                              1, 32'h8000_0000, 0, 0));
    directed.push_back(mk_row(fpa_pkg::CMD_DEC, 32'h8000_0000, 32'hA5A5_5A5A,
                              1, 32'h7FFF_FFFF, 0, 0));
    directed.push_back(mk_row(fpa_pkg::CMD_FROM_INT, 32'd1, 32'hFFFF_FFFF,
                              1, 32'h100, 0, 0));
    directed.push_back(mk_row(fpa_pkg::CMD_FROM_INT, 32'h7FFF_FFFF, 32'd0,
                              0, '0, 0, 0));

    // Hold synchronous reset, then release it.
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      v = directed[i];
      send_op(v.req, v.known, v.want);
    end

    // Random traffic with occasional zero-gap bursts on both sides.
    for (int k = 0; k < N_RANDOM; k++) begin
      if ($urandom_range(0, 59) == 0) no_idle = ~no_idle;
      r.cmd       = fpa_pkg::cmd_e'($urandom_range(0, 14));
      r.operand_a = pick_operand();
      if ($urandom_range(0, 7) == 0) r.operand_b = r.operand_a;
      else r.operand_b = pick_operand();
      if (fpa_pkg::cmd_e'(r.cmd) == fpa_pkg::CMD_DIV && $urandom_range(0, 9) == 0)
        r.operand_b = '0;
      send_op(r, 1'b0, none);
    end

    @(negedge clk);
    req_valid <= 1'b0;
    no_idle = 1'b0;

    // Drain outstanding responses, then give the pipeline time to misbehave.
    while (alu_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("summary: %0d commands sent (%0d directed), %0d responses checked",
             n_sent, directed.size(), n_checked);
    $display("summary: %0d divide-by-zero responses, one %0d-cycle output hold-off",
             n_dz_seen, HOLD_LEN);
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("%0d responses failed", mismatches);
      $display("tb: errors");
    end
    $finish;
  end

endmodule
